// ----- hdl/ott_pkg.sv -----
// Package for the one-shot timer table: item types, slot entry type and
// operation codes. Used by every module of the block; depends on nothing.
package ott_pkg;

  localparam int SLOTS_DEF = 16;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_ADD  = 2'd1;
  localparam logic [1:0] FUNC_DEL  = 2'd2;
  localparam logic [1:0] FUNC_FIND = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] timer_id;
    logic [7:0] period;
  } ott_in_t;

  typedef struct packed {
    logic       expired_valid;
    logic [7:0] expired_id;
    logic       found;
    logic       status;
    logic       last;
  } ott_out_t;

  typedef struct packed {
    logic       armed;
    logic [7:0] owner;
    logic [7:0] remaining;
  } ott_entry_t;

endpackage

// ----- hdl/ott_cell.sv -----
// One cell of the timer ring: holds one slot entry and takes its
// neighbor's entry when the ring shifts. Depends on ott_pkg.
module ott_cell import ott_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       shift_en,
  input  ott_entry_t d_in,
  output ott_entry_t q
);

  logic       armed_r;
  logic [7:0] owner_r;
  logic [7:0] remaining_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
    end else if (shift_en) begin
      armed_r <= d_in.armed;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      owner_r     <= d_in.owner;
      remaining_r <= d_in.remaining;
    end
  end

  assign q = '{armed: armed_r, owner: owner_r, remaining: remaining_r};

endmodule

// ----- hdl/ott_ring.sv -----
// Ring of timer cells. Each shift moves every entry one cell toward the
// head; the tail takes the written-back entry. Depends on ott_pkg, ott_cell.
module ott_ring import ott_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       shift_en,
  input  ott_entry_t tail_in,
  output ott_entry_t head_out
);

  ott_entry_t link [SLOTS];

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    ott_entry_t cell_d;
    if (k == SLOTS - 1) begin : g_tail
      assign cell_d = tail_in;
    end else begin : g_mid
      assign cell_d = link[k+1];
    end
    ott_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d_in     (cell_d),
      .q        (link[k])
    );
  end

  assign head_out = link[0];

endmodule

// ----- hdl/one_shot_timer_table_unit.sv -----
// Top level of the one-shot timer table: item handshakes, sequencer and
// output register around the cell ring. Depends on ott_pkg and ott_ring.
//
// Usage: items enter on in_valid/in_ready with in_data (func, timer_id,
// period) and results leave on out_valid/out_ready with out_data. Every
// item yields at least one result; the final one has last set. A tick
// yields one result per expired timer in ascending slot order, or a single
// empty result when nothing expires.
// The slot entries sit in a ring of SLOTS cells that rotates one slot past
// the head per cycle unless a stalled expiry holds it; each scan is one full
// lap of the ring. Tick, delete, find and re-arm take one lap before the
// final result; an add that places a new timer takes a second lap.
// The final result is registered from the flush state after the last lap.
// When the receiver stalls, the ring pauses while an expiry waits to be
// handed to the output register, and the final result waits in place.
// Reset disarms every slot at once; no clearing pass is needed.
module one_shot_timer_table_unit import ott_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ott_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ott_out_t out_data
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_PLACE = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] op_r;
  logic [7:0] id_r;
  logic [7:0] period_r;
  logic [IDX_W-1:0] step_r, step_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic       match_r, match_nxt;
  logic       free_found_r, free_found_nxt;
  logic       pend_valid_r, pend_valid_nxt;
  logic [7:0] pend_id_r, pend_id_nxt;
  logic       out_valid_r, out_valid_nxt;
  ott_out_t   out_data_r, out_data_nxt;

  ott_entry_t head, wb;
  logic       shift_en;
  logic       out_free;
  logic       out_load;
  logic       last_step;
  logic       hit;
  logic [7:0] dec;

  ott_ring #(.SLOTS(SLOTS)) u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (shift_en),
    .tail_in  (wb),
    .head_out (head)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_ready;
  assign last_step = (step_r == IDX_W'(SLOTS - 1));
  assign hit       = head.armed && (head.owner == id_r);
  assign dec       = head.remaining - 8'd1;

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    free_idx_nxt   = free_idx_r;
    match_nxt      = match_r;
    free_found_nxt = free_found_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    wb             = head;
    shift_en       = 1'b0;
    out_load       = 1'b0;
    out_data_nxt   = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt      = ST_SCAN;
          step_nxt       = '0;
          match_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          pend_valid_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        shift_en = 1'b1;
        case (op_r)
          FUNC_TICK: begin
            if (head.armed) begin
              wb.remaining = dec;
              if (dec == 8'd0) begin
                wb.armed = 1'b0;
                if (pend_valid_r) begin
                  if (out_free) begin
                    out_load     = 1'b1;
                    out_data_nxt = '{expired_valid: 1'b1, expired_id: pend_id_r,
                                     found: 1'b0, status: 1'b0, last: 1'b0};
                  end else begin
                    shift_en = 1'b0;
                  end
                end
                if (shift_en) begin
                  pend_valid_nxt = 1'b1;
                  pend_id_nxt    = head.owner;
                end
              end
            end
          end
          FUNC_ADD: begin
            if (hit) begin
              wb.remaining = period_r;
              match_nxt    = 1'b1;
            end
            if (!head.armed && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_idx_nxt   = step_r;
            end
          end
          FUNC_DEL: begin
            if (hit) begin
              wb.armed  = 1'b0;
              match_nxt = 1'b1;
            end
          end
          default: begin
            if (hit) begin
              match_nxt = 1'b1;
            end
          end
        endcase
        if (shift_en) begin
          if (last_step) begin
            step_nxt = '0;
            if (op_r == FUNC_ADD && !match_nxt && free_found_nxt) begin
              state_nxt = ST_PLACE;
            end else begin
              state_nxt = ST_FLUSH;
            end
          end else begin
            step_nxt = step_r + IDX_W'(1);
          end
        end
      end
      ST_PLACE: begin
        shift_en = 1'b1;
        if (step_r == free_idx_r) begin
          wb = '{armed: 1'b1, owner: id_r, remaining: period_r};
        end
        if (last_step) begin
          step_nxt  = '0;
          state_nxt = ST_FLUSH;
        end else begin
          step_nxt = step_r + IDX_W'(1);
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          out_data_nxt = '{expired_valid: 1'b0, expired_id: 8'd0,
                           found: 1'b0, status: 1'b0, last: 1'b1};
          case (op_r)
            FUNC_TICK: begin
              out_data_nxt.expired_valid = pend_valid_r;
              out_data_nxt.expired_id    = pend_valid_r ? pend_id_r : 8'd0;
            end
            FUNC_ADD: begin
              out_data_nxt.status = !match_r && !free_found_r;
            end
            default: begin
              out_data_nxt.found = match_r;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      match_r      <= 1'b0;
      free_found_r <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      match_r      <= match_nxt;
      free_found_r <= free_found_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    free_idx_r <= free_idx_nxt;
    pend_id_r  <= pend_id_nxt;
    out_data_r <= out_data_nxt;
    if (in_valid && in_ready) begin
      op_r     <= in_data.func;
      id_r     <= in_data.timer_id;
      period_r <= in_data.period;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state is not one-hot");

  a_idle_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (step_r == '0))
    else $error("ring lap not complete when returning to idle");

  a_ring_still: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_FLUSH) |-> !shift_en)
    else $error("ring shifted outside a lap");

  a_scan_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && out_load) |=>
      (out_valid_r && out_data_r.expired_valid && !out_data_r.last))
    else $error("expiry handed out during a lap is malformed");

  a_flush_final: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && out_free) |=>
      (state_r == ST_IDLE && out_valid_r && out_data_r.last))
    else $error("final result not delivered on flush");

endmodule
